/* sv/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

/* sv/hitd_pkg.sv */
// ----------------------------------------------------------------------------
// hitd_pkg
// types and constants of the in-band tree huffman decoder
// ----------------------------------------------------------------------------
`default_nettype none
package hitd_pkg;
    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ROOTLEAF = 2'd2;

    typedef enum logic [1:0] {PH_TREE, PH_SYMBOL, PH_DECODE, PH_ERROR} phase_t;

    // queue entry from front to back
    typedef struct packed {
        logic       emit_err;
        logic [1:0] err_code;
        logic       walk;
        logic       code_bit;
    } job_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       symbol_end;
        logic [1:0] status;
    } res_t;
endpackage
`default_nettype wire

/* sv/hitd_if.sv */
// ----------------------------------------------------------------------------
// hitd_in_if / hitd_out_if
// valid/ready channels of the decoder
// ----------------------------------------------------------------------------
`default_nettype none
interface hitd_in_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic stream_start;
    modport source (output valid, output code_bit, output stream_start, input ready);
    modport sink (input valid, input code_bit, input stream_start, output ready);
endinterface

interface hitd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       symbol_end;
    logic [1:0] status;
    modport source (output valid, output out_byte, output symbol_end, output status,
                    input ready);
    modport sink (input valid, input out_byte, input symbol_end, input status,
                  output ready);
endinterface
`default_nettype wire

/* sv/hitd_top.sv */
// ----------------------------------------------------------------------------
// hitd_top
// decoupled front (tree build) and back (walk and emit) of the decoder
// ----------------------------------------------------------------------------
`default_nettype none
module hitd_top #(
    parameter int MAX_LEAVES       = 256,
    parameter int MAX_SYMBOL_BYTES = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [3:0] cfg_data,
    hitd_in_if.sink   in_ch,
    hitd_out_if.source out_ch
);
    import hitd_pkg::*;
    localparam int NODE_CAP = 2 * MAX_LEAVES - 1;
    localparam int NW = $clog2(NODE_CAP + 1);
    localparam int SW = $clog2(MAX_LEAVES + 1);
    localparam int SAW = $clog2(MAX_LEAVES);
    localparam int WW = 8 * MAX_SYMBOL_BYTES;
    localparam int BLW = $clog2(WW + 1);
    localparam int BCW = $clog2(MAX_SYMBOL_BYTES + 1);

    logic [3:0] sb_reg;
    logic [BCW-1:0] nb;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) sb_reg <= 4'd1;
        else if (cfg_we) sb_reg <= cfg_data;
    end
    always_comb
    begin
        if (sb_reg == 4'd0) nb = BCW'(1);
        else if (32'(sb_reg) > MAX_SYMBOL_BYTES) nb = BCW'(MAX_SYMBOL_BYTES);
        else nb = BCW'(sb_reg);
    end

    // node table memories
    logic [NW-1:0] lc_mem [NODE_CAP];
    logic [NW-1:0] rc_mem [NODE_CAP];
    logic          lf_mem [NODE_CAP];
    logic [WW-1:0] lw_mem [NODE_CAP];
    logic [NW:0]   stk_mem [MAX_LEAVES];

    // front state
    phase_t phase_reg;
    logic [SW-1:0] sd_reg;
    logic [NW-1:0] nu_reg;
    logic [WW-1:0] ws_reg;
    logic [BLW-1:0] bl_reg;
    logic [NW:0] top_reg;           // cached top entry of stack
    logic top_busy_reg;             // 1 after a pop that leaves the stack non-empty

    // queue between front and back (2 deep)
    job_t q_mem [2];
    logic q_wp_reg, q_rp_reg;
    logic [1:0] q_cnt_reg;
    logic q_push, q_pop;
    job_t q_in;

    // back state
    logic back_busy_reg;  // reading node
    logic [NW-1:0] walk_reg;
    logic jb_bit_reg;
    logic [NW-1:0] rd_l, rd_r;
    logic emit_reg;
    logic [WW-1:0] ew_reg;
    logic [BCW-1:0] ek_reg;
    logic [NW-1:0] nxt_reg;
    logic nxt_wait_reg;
    res_t res_reg;
    logic ov_reg;
    logic back_idle;

    // front accept: stream_start needs the back drained
    logic in_fire;
    assign back_idle = (q_cnt_reg == 2'd0) && !back_busy_reg && !nxt_wait_reg &&
                       !emit_reg && !ov_reg;
    assign in_ch.ready = (q_cnt_reg != 2'd2) && !top_busy_reg &&
                         (!in_ch.stream_start || back_idle);
    assign in_fire = in_ch.valid && in_ch.ready;

    // front combinational
    phase_t ph;
    logic [SW-1:0] sd;
    logic [NW-1:0] nu;
    logic [NW:0] slot;
    logic attach, push2, push1;
    logic lw_we, lf_we, lf_val;
    always_comb
    begin
        ph = in_ch.stream_start ? PH_TREE : phase_reg;
        sd = in_ch.stream_start ? '0 : sd_reg;
        nu = in_ch.stream_start ? '0 : nu_reg;
        q_push = 1'b0;
        q_in = '0;
        attach = 1'b0;
        push1 = 1'b0;
        push2 = 1'b0;
        lw_we = 1'b0;
        lf_we = 1'b0;
        lf_val = 1'b0;
        slot = top_reg;
        if (in_fire)
        begin
            unique case (ph)
                PH_TREE:
                begin
                    if (32'(nu) >= NODE_CAP)
                    begin
                        q_push = 1'b1; q_in.emit_err = 1'b1; q_in.err_code = ST_OVERFLOW;
                    end
                    else if (in_ch.code_bit)
                    begin
                        if (nu == '0)
                        begin
                            q_push = 1'b1; q_in.emit_err = 1'b1;
                            q_in.err_code = ST_ROOTLEAF;
                        end
                        else
                        begin
                            attach = (sd != '0); lf_we = 1'b1; lf_val = 1'b1;
                        end
                    end
                    else if (nu != '0)
                    begin
                        if (32'(sd) + 1 > MAX_LEAVES)
                        begin
                            q_push = 1'b1; q_in.emit_err = 1'b1;
                            q_in.err_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            attach = (sd != '0); push1 = 1'b1; lf_we = 1'b1;
                        end
                    end
                    else if (32'(sd) + 2 > MAX_LEAVES)
                    begin
                        q_push = 1'b1; q_in.emit_err = 1'b1; q_in.err_code = ST_OVERFLOW;
                    end
                    else
                    begin
                        push2 = 1'b1; lf_we = 1'b1;
                    end
                end
                PH_SYMBOL:
                begin
                    lw_we = (bl_reg <= BLW'(1));
                end
                PH_DECODE:
                begin
                    q_push = 1'b1; q_in.walk = 1'b1; q_in.code_bit = in_ch.code_bit;
                end
                default: ;
            endcase
        end
    end

    logic [WW-1:0] ws_n;
    assign ws_n = {ws_reg[WW-2:0], in_ch.code_bit};

    always_ff @(posedge clk)
    begin
        if (lf_we) lf_mem[nu] <= lf_val;
        if (lw_we) lw_mem[NW'(nu_reg - NW'(1))] <= ws_n;
        if (attach)
        begin
            if (slot[0]) rc_mem[slot[NW:1]] <= nu;
            else lc_mem[slot[NW:1]] <= nu;
        end
        // push of internal node: after attach sd-1, push right then left
        if (push1)
        begin
            stk_mem[SAW'(sd - SW'(1))] <= {nu, 1'b1};
            stk_mem[SAW'(sd)] <= {nu, 1'b0};
        end
        if (push2)
        begin
            stk_mem[SAW'(sd)] <= {nu, 1'b1};
            stk_mem[SAW'(sd + SW'(1))] <= {nu, 1'b0};
        end
    end

    // stack top cache: top_reg = stk[sd-1]; refreshed by a read after a pop
    logic [NW:0] stk_rd_reg;
    logic refill_reg;
    logic refill2_reg;
    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stk_mem[SAW'(sd_reg - SW'(1))];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TREE; sd_reg <= '0; nu_reg <= '0; ws_reg <= '0;
            bl_reg <= '0; top_reg <= '0; top_busy_reg <= 1'b0;
            refill_reg <= 1'b0; refill2_reg <= 1'b0;
        end
        else
        begin
            refill_reg <= 1'b0;
            refill2_reg <= refill_reg;
            top_busy_reg <= 1'b0;
            if (refill2_reg) top_reg <= stk_rd_reg;
            if (in_fire)
            begin
                if (in_ch.stream_start)
                begin
                    phase_reg <= PH_TREE; sd_reg <= '0; nu_reg <= '0;
                end
                unique case (ph)
                    PH_TREE:
                    begin
                        if (q_push) phase_reg <= PH_ERROR;
                        else if (in_ch.code_bit)
                        begin
                            nu_reg <= nu + NW'(1);
                            ws_reg <= '0;
                            bl_reg <= BLW'({nb, 3'b000});
                            phase_reg <= PH_SYMBOL;
                            if (attach)
                            begin
                                sd_reg <= sd - SW'(1);
                                if (sd > SW'(1))
                                begin
                                    refill_reg <= 1'b1; top_busy_reg <= 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            nu_reg <= nu + NW'(1);
                            top_reg <= {nu, 1'b0};
                            sd_reg <= push1 ? (attach ? sd + SW'(1) : sd + SW'(2))
                                            : sd + SW'(2);
                        end
                    end
                    PH_SYMBOL:
                    begin
                        ws_reg <= ws_n;
                        if (bl_reg != '0) bl_reg <= bl_reg - BLW'(1);
                        if (lw_we) phase_reg <= (sd_reg == '0) ? PH_DECODE : PH_TREE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // queue
    always_ff @(posedge clk)
    begin
        if (q_push) q_mem[q_wp_reg] <= q_in;
    end
    job_t q_head;
    assign q_head = q_mem[q_rp_reg];

    // back: pop a job when nothing in progress
    logic out_free;
    assign out_free = !out_ch.valid || out_ch.ready;
    assign q_pop = (q_cnt_reg != 2'd0) && !back_busy_reg && !nxt_wait_reg &&
                   !emit_reg && !ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg <= 1'b0; q_rp_reg <= 1'b0; q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push) q_wp_reg <= ~q_wp_reg;
            if (q_pop) q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(q_push) - 2'(q_pop);
        end
    end

    // node reads: children at walk node, then leaf flag and word at next node
    logic nleaf_reg;
    logic [WW-1:0] nword_reg;
    logic [NW-1:0] nxt_sel;
    always_ff @(posedge clk)
    begin
        rd_l <= lc_mem[walk_reg];
        rd_r <= rc_mem[walk_reg];
        nleaf_reg <= lf_mem[nxt_sel];
        nword_reg <= lw_mem[nxt_sel];
    end
    always_comb
    begin
        nxt_sel = jb_bit_reg ? rd_r : rd_l;
        if (32'(nxt_sel) >= NODE_CAP) nxt_sel = '0;
    end

    logic [BCW+2:0] sh;
    assign sh = {ek_reg - BCW'(1), 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_busy_reg <= 1'b0; nxt_wait_reg <= 1'b0; emit_reg <= 1'b0;
            walk_reg <= '0; ov_reg <= 1'b0; jb_bit_reg <= 1'b0;
            nxt_reg <= '0; ek_reg <= '0; ew_reg <= '0; res_reg <= '0;
        end
        else
        begin
            if (in_fire && in_ch.stream_start) walk_reg <= '0;
            if (out_free) ov_reg <= 1'b0;
            if (q_pop)
            begin
                if (q_head.emit_err)
                begin
                    ov_reg <= 1'b1;
                    res_reg <= '{out_byte: 8'd0, symbol_end: 1'b0,
                                 status: q_head.err_code};
                end
                else
                begin
                    back_busy_reg <= 1'b1; jb_bit_reg <= q_head.code_bit;
                end
            end
            if (back_busy_reg)
            begin
                back_busy_reg <= 1'b0; nxt_wait_reg <= 1'b1; nxt_reg <= nxt_sel;
            end
            if (nxt_wait_reg)
            begin
                nxt_wait_reg <= 1'b0;
                if (nleaf_reg)
                begin
                    emit_reg <= 1'b1; ew_reg <= nword_reg; ek_reg <= nb;
                    walk_reg <= '0;
                end
                else walk_reg <= nxt_reg;
            end
            if (emit_reg && out_free)
            begin
                ov_reg <= 1'b1;
                res_reg <= '{out_byte: 8'(ew_reg >> sh),
                             symbol_end: (ek_reg == BCW'(1)), status: ST_DATA};
                ek_reg <= ek_reg - BCW'(1);
                if (ek_reg == BCW'(1)) emit_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.out_byte = res_reg.out_byte;
    assign out_ch.symbol_end = res_reg.symbol_end;
    assign out_ch.status = res_reg.status;
endmodule
`default_nettype wire

/* sv/huffman_inband_tree_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_inband_tree_decoder
// huffman decoder with its code tree sent in band ahead of the data
// ----------------------------------------------------------------------------
// in_ch carries one stream bit per request with stream_start on a first bit.
// cfg_we/cfg_data write symbol_bytes at any idle time; reset value 1.
// the front builds the node table from tree bits, one bit per cycle; a stack
// of open child slots is kept in memory with its top cached in a register,
// and a leaf that pops the stack, leaving it non-empty, holds off the next bit.
// data bits go through a two-entry queue to the back, which ends each bit
// before it takes the next: child read, leaf and word read, emit decision.
// a leaf gives symbol_bytes results on out_ch, one per cycle unless stalled.
// results sit in an output register; a stalled receiver stops the back,
// the queue fills and in_ch.ready falls. a bit with stream_start waits until
// the back has drained. reset clears control state; the node table needs
// no clearing pass since it is always written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none
module huffman_inband_tree_decoder #(
    parameter int MAX_LEAVES       = 256,
    parameter int MAX_SYMBOL_BYTES = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [3:0] cfg_data,
    hitd_in_if.sink    in_ch,
    hitd_out_if.source out_ch
);
    hitd_top #(.MAX_LEAVES(MAX_LEAVES), .MAX_SYMBOL_BYTES(MAX_SYMBOL_BYTES)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

/* sv/hitd_checker.sv */
// ----------------------------------------------------------------------------
// hitd_checker
// port-level checks of the decoder
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hitd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_start,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_end,
    input wire logic [1:0] out_status
);
    import hitd_pkg::*;
    `CHK_IMPL(a_stat, clk, rst_n, out_valid, out_status != 2'd3)
    `CHK_IMPL(a_err_end, clk, rst_n, out_valid && out_status != ST_DATA, !out_end)
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `CHK_IMPL(a_start_idle, clk, rst_n, in_valid && in_ready && in_start, !out_valid)
endmodule

bind huffman_inband_tree_decoder hitd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_start(in_ch.stream_start), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_end(out_ch.symbol_end), .out_status(out_ch.status)
);
`default_nettype wire
